FILE: sv/lfu_pkg.sv
// lfu cache table shared types and constants
`default_nettype none

package lfu_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CNT_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [CNT_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;
   localparam logic [CNT_W-1:0] CNT_ONE   = 32'd1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // running outcome of one scan over the table
   typedef struct packed {
      logic             found;
      logic             have_free;
      logic             have_victim;
      logic [VAL_W-1:0] hit_value;
      logic [CNT_W-1:0] hit_count;
      logic [KEY_W-1:0] victim_key;
   } lfu_scan_res_type;

endpackage

`default_nettype wire

FILE: sv/lfu_chan_if.sv
// request and response channel interfaces of the lfu cache table
`default_nettype none

interface lfu_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [lfu_pkg::KEY_W-1:0]  lookup_key;
   logic [lfu_pkg::VAL_W-1:0]  write_value;

   modport source (output valid, output opcode, output lookup_key, output write_value,
                   input ready);
   modport sink   (input valid, input opcode, input lookup_key, input write_value,
                   output ready);
endinterface

interface lfu_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [lfu_pkg::VAL_W-1:0]  read_value;
   logic                       evicted;
   logic [lfu_pkg::KEY_W-1:0]  evicted_key;

   modport source (output valid, output found, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input found, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

`default_nettype wire

FILE: sv/lfu_ram.sv
// generic single write port, single registered read port ram
`default_nettype none

module lfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/lfu_scan.sv
// shared compare unit: key match, victim selection and free slot search
`default_nettype none

module lfu_scan #(
   parameter int ENTRIES = 16,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          step_en,
   input  logic [IDX_W-1:0]              step_idx,
   input  logic                          step_valid,
   input  logic [lfu_pkg::KEY_W-1:0]     step_key,
   input  logic [lfu_pkg::VAL_W-1:0]     step_value,
   input  logic [lfu_pkg::CNT_W-1:0]     step_count,
   input  logic [IDX_W-1:0]              step_rank,
   input  logic [lfu_pkg::KEY_W-1:0]     match_key,
   output lfu_pkg::lfu_scan_res_type     res,
   output logic [IDX_W-1:0]              hit_idx,
   output logic [IDX_W-1:0]              hit_rank,
   output logic [IDX_W-1:0]              victim_idx,
   output logic [IDX_W-1:0]              victim_rank,
   output logic [IDX_W-1:0]              free_idx
);

   logic                        found_ff;
   logic                        have_free_ff;
   logic                        have_victim_ff;
   logic [IDX_W-1:0]            hit_idx_ff;
   logic [IDX_W-1:0]            hit_rank_ff;
   logic [lfu_pkg::VAL_W-1:0]   hit_value_ff;
   logic [lfu_pkg::CNT_W-1:0]   hit_count_ff;
   logic [IDX_W-1:0]            victim_idx_ff;
   logic [IDX_W-1:0]            victim_rank_ff;
   logic [lfu_pkg::CNT_W-1:0]   victim_count_ff;
   logic [lfu_pkg::KEY_W-1:0]   victim_key_ff;
   logic [IDX_W-1:0]            free_idx_ff;
   logic                        better_victim;

   // lower use count wins, then the less recent entry
   assign better_victim = !have_victim_ff || (step_count < victim_count_ff) ||
                          ((step_count == victim_count_ff) && (step_rank < victim_rank_ff));

   // accumulate one entry per step
   always_ff @(posedge clock) begin
      if (reset || start) begin
         found_ff       <= 1'b0;
         have_free_ff   <= 1'b0;
         have_victim_ff <= 1'b0;
      end else if (step_en) begin
         if (step_valid) begin
            if (!found_ff && (step_key == match_key)) begin
               found_ff     <= 1'b1;
               hit_idx_ff   <= step_idx;
               hit_rank_ff  <= step_rank;
               hit_value_ff <= step_value;
               hit_count_ff <= step_count;
            end
            if (better_victim) begin
               have_victim_ff  <= 1'b1;
               victim_idx_ff   <= step_idx;
               victim_rank_ff  <= step_rank;
               victim_count_ff <= step_count;
               victim_key_ff   <= step_key;
            end
         end else if (!have_free_ff) begin
            have_free_ff <= 1'b1;
            free_idx_ff  <= step_idx;
         end
      end
   end

   assign res = '{found:       found_ff,
                  have_free:   have_free_ff,
                  have_victim: have_victim_ff,
                  hit_value:   hit_value_ff,
                  hit_count:   hit_count_ff,
                  victim_key:  victim_key_ff};
   assign hit_idx         = hit_idx_ff;
   assign hit_rank        = hit_rank_ff;
   assign victim_idx      = victim_idx_ff;
   assign victim_rank     = victim_rank_ff;
   assign free_idx        = free_idx_ff;

endmodule

`default_nettype wire

FILE: sv/lfu_cache_table.sv
// lfu cache table: fully associative store, least frequently used replacement
// a request is taken only when idle; the block scans every entry, decides, runs a rank
// update pass for hits and evicting puts, writes back where needed and then responds,
// once the response register is free, before it takes the next request; the scan and
// the rank pass each read one entry per cycle through the single read port of the entry rams
// reset: synchronous; table empty, capacity 16, no response pending
`default_nettype none

module lfu_cache_table #(
   parameter int ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   lfu_req_if.sink                     req_chan,
   lfu_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [lfu_pkg::CAP_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
   localparam logic [OCC_W-1:0] PASS_END = OCC_W'(ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SWEEP,
      ST_WRITE,
      ST_RESP
   } state_type;

   state_type                   state_ff;
   logic [lfu_pkg::CAP_W-1:0]   cap_ff;
   logic [ENTRIES-1:0]          valid_ff;
   logic [OCC_W-1:0]            occ_ff;
   logic                        op_ff;
   logic [lfu_pkg::KEY_W-1:0]   key_ff;
   logic [lfu_pkg::VAL_W-1:0]   wval_ff;
   logic [OCC_W-1:0]            rd_cnt_ff;
   logic                        pipe_vld_ff;
   logic [IDX_W-1:0]            pipe_idx_ff;
   logic [IDX_W-1:0]            old_rank_ff;
   logic [IDX_W-1:0]            tgt_ff;
   logic [IDX_W-1:0]            tgt_rank_ff;
   logic [lfu_pkg::CNT_W-1:0]   tgt_cnt_ff;
   logic                        do_insert_ff;
   logic                        do_value_ff;
   logic                        found_ff;
   logic [lfu_pkg::VAL_W-1:0]   rdval_ff;
   logic                        ev_ff;
   logic [lfu_pkg::KEY_W-1:0]   evkey_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;
   logic [lfu_pkg::VAL_W-1:0]   rsp_rdval_ff;
   logic                        rsp_ev_ff;
   logic [lfu_pkg::KEY_W-1:0]   rsp_evkey_ff;

   logic                        accept;
   logic                        pass_done;
   logic [IDX_W-1:0]            rd_addr;
   logic [CMP_W-1:0]            cap_w;
   logic [CMP_W-1:0]            occ_w;
   logic [IDX_W-1:0]            last_rank;
   logic [lfu_pkg::CNT_W-1:0]   bumped_cnt;
   logic                        pipe_entry_valid;

   logic                        evict_now;
   state_type                   decide_state;
   logic [lfu_pkg::VAL_W-1:0]   rdval_in;
   logic                        ev_in;
   logic [lfu_pkg::KEY_W-1:0]   evkey_in;
   logic                        do_insert_in;
   logic                        do_value_in;
   logic [IDX_W-1:0]            old_rank_in;
   logic [IDX_W-1:0]            tgt_in;
   logic [IDX_W-1:0]            tgt_rank_in;
   logic [lfu_pkg::CNT_W-1:0]   tgt_cnt_in;

   logic [lfu_pkg::KEY_W-1:0]   key_rd;
   logic [lfu_pkg::VAL_W-1:0]   val_rd;
   logic [lfu_pkg::CNT_W-1:0]   cnt_rd;
   logic [IDX_W-1:0]            rank_rd;
   logic                        rank_we;
   logic [IDX_W-1:0]            rank_waddr;
   logic [IDX_W-1:0]            rank_wdata;
   logic                        sweep_dec;

   lfu_pkg::lfu_scan_res_type   scan_res;
   logic [IDX_W-1:0]            hit_idx;
   logic [IDX_W-1:0]            hit_rank;
   logic [IDX_W-1:0]            victim_idx;
   logic [IDX_W-1:0]            victim_rank;
   logic [IDX_W-1:0]            free_idx;

   // handshake and pass control
   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign accept           = req_chan.valid && (state_ff == ST_IDLE);
   assign pass_done        = (rd_cnt_ff == PASS_END);
   assign rd_addr          = rd_cnt_ff[IDX_W-1:0];
   assign pipe_entry_valid = valid_ff[pipe_idx_ff];

   // effective capacity and derived values
   assign cap_w      = (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_ff);
   assign occ_w      = CMP_W'(occ_ff);
   assign last_rank  = IDX_W'(occ_ff - OCC_W'(1));
   assign bumped_cnt = (scan_res.hit_count == lfu_pkg::CNT_MAX) ? lfu_pkg::CNT_MAX :
                       scan_res.hit_count + lfu_pkg::CNT_ONE;

   // rank update pass closes the gap above the removed or touched rank
   assign sweep_dec  = (state_ff == ST_SWEEP) && pipe_vld_ff && pipe_entry_valid &&
                       (rank_rd > old_rank_ff);
   assign rank_we    = sweep_dec || (state_ff == ST_WRITE);
   assign rank_waddr = (state_ff == ST_SWEEP) ? pipe_idx_ff : tgt_ff;
   assign rank_wdata = (state_ff == ST_SWEEP) ? (rank_rd - IDX_W'(1)) : tgt_rank_ff;

   // outcome of the scan: response fields and the write-back plan
   always_comb begin
      evict_now    = 1'b0;
      decide_state = ST_RESP;
      rdval_in     = '0;
      ev_in        = 1'b0;
      evkey_in     = '0;
      do_insert_in = 1'b0;
      do_value_in  = 1'b0;
      old_rank_in  = hit_rank;
      tgt_in       = hit_idx;
      tgt_rank_in  = last_rank;
      tgt_cnt_in   = bumped_cnt;
      if (op_ff == lfu_pkg::OP_GET) begin
         // get: hit touches the entry, miss answers at once
         if (scan_res.found) begin
            rdval_in     = scan_res.hit_value;
            decide_state = ST_SWEEP;
         end
      end else if (cap_w != '0) begin
         // capacity zero ignores the put entirely
         if (scan_res.found) begin
            // put on a present key: overwrite and touch
            do_value_in  = 1'b1;
            decide_state = ST_SWEEP;
         end else begin
            // put on a new key
            tgt_cnt_in = lfu_pkg::CNT_ONE;
            if ((occ_w >= cap_w) && (occ_ff != '0) && scan_res.have_victim) begin
               evict_now    = 1'b1;
               old_rank_in  = victim_rank;
               ev_in        = 1'b1;
               evkey_in     = scan_res.victim_key;
               do_insert_in = 1'b1;
               do_value_in  = 1'b1;
               tgt_in       = (scan_res.have_free && (free_idx < victim_idx)) ?
                              free_idx : victim_idx;
               decide_state = ST_SWEEP;
            end else if (scan_res.have_free) begin
               do_insert_in = 1'b1;
               do_value_in  = 1'b1;
               tgt_in       = free_idx;
               tgt_rank_in  = IDX_W'(occ_ff);
               decide_state = ST_WRITE;
            end
         end
      end
   end

   // entry stores
   lfu_ram #(.WIDTH(lfu_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   ((state_ff == ST_WRITE) && do_insert_ff),
      .wr_addr (tgt_ff),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   lfu_ram #(.WIDTH(lfu_pkg::VAL_W), .DEPTH(ENTRIES)) u_val_ram (
      .clock   (clock),
      .wr_en   ((state_ff == ST_WRITE) && do_value_ff),
      .wr_addr (tgt_ff),
      .wr_data (wval_ff),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   lfu_ram #(.WIDTH(lfu_pkg::CNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_WRITE),
      .wr_addr (tgt_ff),
      .wr_data (tgt_cnt_ff),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd)
   );

   lfu_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_waddr),
      .wr_data (rank_wdata),
      .rd_addr (rd_addr),
      .rd_data (rank_rd)
   );

   // shared compare unit fed one entry per cycle during the scan
   lfu_scan #(.ENTRIES(ENTRIES)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .step_en     ((state_ff == ST_SCAN) && pipe_vld_ff),
      .step_idx    (pipe_idx_ff),
      .step_valid  (pipe_entry_valid),
      .step_key    (key_rd),
      .step_value  (val_rd),
      .step_count  (cnt_rd),
      .step_rank   (rank_rd),
      .match_key   (key_ff),
      .res         (scan_res),
      .hit_idx     (hit_idx),
      .hit_rank    (hit_rank),
      .victim_idx  (victim_idx),
      .victim_rank (victim_rank),
      .free_idx    (free_idx)
   );

   // sequencer, table bookkeeping and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= lfu_pkg::CAP_RESET;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rd_cnt_ff    <= '0;
         pipe_vld_ff  <= 1'b0;
         do_insert_ff <= 1'b0;
         do_value_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         // response taken; the response state reloads it on its own
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff       <= req_chan.opcode;
                  key_ff      <= req_chan.lookup_key;
                  wval_ff     <= req_chan.write_value;
                  rd_cnt_ff   <= '0;
                  pipe_vld_ff <= 1'b0;
                  state_ff    <= ST_SCAN;
               end
            end

            ST_SCAN, ST_SWEEP: begin
               pipe_vld_ff <= !pass_done;
               pipe_idx_ff <= rd_addr;
               if (!pass_done) begin
                  rd_cnt_ff <= rd_cnt_ff + OCC_W'(1);
               end else if (state_ff == ST_SCAN) begin
                  state_ff <= ST_DECIDE;
               end else begin
                  state_ff <= ST_WRITE;
               end
            end

            ST_DECIDE: begin
               rd_cnt_ff    <= '0;
               pipe_vld_ff  <= 1'b0;
               found_ff     <= scan_res.found;
               rdval_ff     <= rdval_in;
               ev_ff        <= ev_in;
               evkey_ff     <= evkey_in;
               do_insert_ff <= do_insert_in;
               do_value_ff  <= do_value_in;
               old_rank_ff  <= old_rank_in;
               tgt_ff       <= tgt_in;
               tgt_rank_ff  <= tgt_rank_in;
               tgt_cnt_ff   <= tgt_cnt_in;
               state_ff     <= decide_state;
               // victim leaves the table before the rank pass
               if (evict_now) begin
                  valid_ff[victim_idx] <= 1'b0;
                  occ_ff               <= occ_ff - OCC_W'(1);
               end
            end

            ST_WRITE: begin
               if (do_insert_ff) begin
                  valid_ff[tgt_ff] <= 1'b1;
                  occ_ff           <= occ_ff + OCC_W'(1);
               end
               state_ff <= ST_RESP;
            end

            ST_RESP: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  rsp_rdval_ff <= rdval_ff;
                  rsp_ev_ff    <= ev_ff;
                  rsp_evkey_ff <= evkey_ff;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // response channel
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.read_value  = rsp_rdval_ff;
   assign rsp_chan.evicted     = rsp_ev_ff;
   assign rsp_chan.evicted_key = rsp_evkey_ff;

endmodule

`default_nettype wire

FILE: test/lfu_cache_table_test.sv
// self-checking testbench for the lfu cache table with a shadow table predictor

module lfu_cache_table_test;

   localparam int ENTRIES        = 16;
   localparam int KEY_POOL       = 24;
   localparam int PHASE_ITEMS    = 66;
   localparam int DRAIN_CYCLES   = 2 * ENTRIES + 8;
   localparam int WATCHDOG_LIMIT = 3000;

   // one response transaction of the block
   typedef struct packed {
      logic                      found;
      logic [lfu_pkg::VAL_W-1:0] read_value;
      logic                      evicted;
      logic [lfu_pkg::KEY_W-1:0] evicted_key;
   } reply_type;

   // shadow copy of the cache contents plus the queue of predicted responses
   class lfu_shadow_table;
      logic                      live [ENTRIES];
      logic [lfu_pkg::KEY_W-1:0] keys [ENTRIES];
      logic [lfu_pkg::VAL_W-1:0] values [ENTRIES];
      logic [lfu_pkg::CNT_W-1:0] counts [ENTRIES];
      logic [3:0]                ranks [ENTRIES];
      logic [4:0]                occupancy;
      logic [lfu_pkg::CAP_W-1:0] capacity;
      reply_type                 pending_replies [$];
      int                        failures;

      function new();
         foreach (live[i]) begin
            live[i]   = 1'b0;
            keys[i]   = '0;
            values[i] = '0;
            counts[i] = '0;
            ranks[i]  = '0;
         end
         occupancy = '0;
         capacity  = lfu_pkg::CAP_RESET;
         failures  = 0;
      endfunction

      function void set_capacity(logic [lfu_pkg::CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function int outstanding();
         return pending_replies.size();
      endfunction

      // close the rank gap above slot s
      function void close_rank_gap(int s);
         foreach (live[i])
            if (live[i] && ranks[i] > ranks[s])
               ranks[i] = ranks[i] - 1'b1;
      endfunction

      // hit on slot s: most recent, count up with saturation
      function void touch_slot(int s);
         close_rank_gap(s);
         ranks[s] = 4'(occupancy - 1'b1);
         if (counts[s] != lfu_pkg::CNT_MAX)
            counts[s] = counts[s] + 1'b1;
      endfunction

      // work out the response of one accepted request transaction
      function void predict_access(logic op, logic [lfu_pkg::KEY_W-1:0] key,
                                   logic [lfu_pkg::VAL_W-1:0] val);
         reply_type r;
         int        hit;
         int        victim;
         int        slot;
         int        cap;
         r = '0;
         hit = -1;
         victim = -1;
         slot = -1;
         cap = (int'(capacity) > ENTRIES) ? ENTRIES : int'(capacity);
         foreach (live[i])
            if (live[i] && hit < 0 && keys[i] == key)
               hit = i;
         r.found = (hit >= 0);
         if (op == lfu_pkg::OP_GET) begin
            if (hit >= 0) begin
               r.read_value = values[hit];
               touch_slot(hit);
            end
         end else if (cap != 0) begin
            if (hit >= 0) begin
               values[hit] = val;
               touch_slot(hit);
            end else begin
               // full: drop the lowest count, oldest on a tie
               if (int'(occupancy) >= cap && occupancy != 0) begin
                  foreach (live[i])
                     if (live[i] && (victim < 0 || counts[i] < counts[victim] ||
                         (counts[i] == counts[victim] && ranks[i] < ranks[victim])))
                        victim = i;
                  if (victim >= 0) begin
                     r.evicted     = 1'b1;
                     r.evicted_key = keys[victim];
                     live[victim]  = 1'b0;
                     close_rank_gap(victim);
                     occupancy = occupancy - 1'b1;
                  end
               end
               foreach (live[i])
                  if (slot < 0 && !live[i])
                     slot = i;
               if (slot >= 0) begin
                  live[slot]   = 1'b1;
                  keys[slot]   = key;
                  values[slot] = val;
                  counts[slot] = lfu_pkg::CNT_ONE;
                  ranks[slot]  = occupancy[3:0];
                  occupancy    = occupancy + 1'b1;
               end
            end
         end
         pending_replies.insert(pending_replies.size(), r);
      endfunction

      // compare one accepted response with the oldest prediction
      function void check_reply(reply_type got);
         reply_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: response with none outstanding: found %0b read %h evicted %0b key %h",
                     $time, got.found, got.read_value, got.evicted, got.evicted_key);
            failures++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want.found, got.found);
            failures++;
         end
         if (got.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %h, actual %h",
                     $time, want.read_value, got.read_value);
            failures++;
         end
         if (got.evicted !== want.evicted) begin
            $display("%0t: evicted mismatch, expected %0b, actual %0b",
                     $time, want.evicted, got.evicted);
            failures++;
         end
         if (got.evicted_key !== want.evicted_key) begin
            $display("%0t: evicted_key mismatch, expected %h, actual %h",
                     $time, want.evicted_key, got.evicted_key);
            failures++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [lfu_pkg::CAP_W-1:0] csr_wr_data;

   lfu_req_if req_chan ();
   lfu_rsp_if rsp_chan ();

   lfu_shadow_table           shadow;
   logic [lfu_pkg::KEY_W-1:0] key_pool [KEY_POOL];
   bit                        quiet_sender;
   bit                        quiet_receiver;
   int                        idle_cycles;

   lfu_cache_table #(
      .ENTRIES(ENTRIES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // random gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 45);
   endfunction

   // wait at a falling edge until no response is outstanding
   task automatic wait_drained();
      @(negedge clock);
      while (shadow.outstanding() != 0)
         @(negedge clock);
   endtask

   // write the capacity register while the block is idle
   task automatic write_capacity(logic [lfu_pkg::CAP_W-1:0] cap);
      wait_drained();
      repeat (3) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = cap;
      @(negedge clock);
      csr_wr_en = 1'b0;
      shadow.set_capacity(cap);
   endtask

   // drive one request transaction, called at a falling edge
   task automatic send_request(logic op, logic [lfu_pkg::KEY_W-1:0] key,
                               logic [lfu_pkg::VAL_W-1:0] val);
      int gap;
      gap = quiet_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.opcode      = op;
      req_chan.lookup_key  = key;
      req_chan.write_value = val;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   // response side stalls, with calm stretches of no stalls
   initial begin
      int hold_left;
      hold_left = 0;
      quiet_receiver = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready = 1'b1;
            if (!quiet_receiver && $urandom_range(0, 2) == 0)
               hold_left = pick_gap();
         end
         if ($urandom_range(0, 149) == 0)
            quiet_receiver = !quiet_receiver;
      end
   end

   // transaction monitor, predictor feed, response check and watchdog
   always @(posedge clock) begin
      reply_type got;
      bit        moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_chan.valid && req_chan.ready) begin
            shadow.predict_access(req_chan.opcode, req_chan.lookup_key, req_chan.write_value);
            moved = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.found       = rsp_chan.found;
            got.read_value  = rsp_chan.read_value;
            got.evicted     = rsp_chan.evicted;
            got.evicted_key = rsp_chan.evicted_key;
            shadow.check_reply(got);
            moved = 1'b1;
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // main stimulus
   initial begin
      logic [lfu_pkg::CAP_W-1:0] phase_caps [9];
      logic                      op;
      logic [lfu_pkg::KEY_W-1:0] key;
      int                        span;

      shadow = new();
      quiet_sender = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.opcode = lfu_pkg::OP_GET;
      req_chan.lookup_key = '0;
      req_chan.write_value = '0;

      phase_caps = '{5'd16, 5'd3, 5'd0, 5'd8, 5'd31, 5'd1, 5'd5, 5'd17, 5'd12};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++)
         key_pool[i] = $urandom();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty miss, extreme keys and values, update of a present key
      send_request(lfu_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(lfu_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(lfu_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(lfu_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);
      send_request(lfu_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(lfu_pkg::OP_GET, 32'h5555_AAAA, 32'h0000_0000);

      // capacity zero: puts ignored, stored entries still readable
      write_capacity(5'd0);
      send_request(lfu_pkg::OP_PUT, 32'hA5A5_A5A5, 32'hDEAD_BEEF);
      send_request(lfu_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0001);
      send_request(lfu_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);

      // small capacity: evictions by use count
      write_capacity(5'd2);
      send_request(lfu_pkg::OP_PUT, 32'hAAAA_5555, 32'h0F0F_0F0F);
      send_request(lfu_pkg::OP_PUT, 32'h0000_0001, 32'hF0F0_F0F0);
      send_request(lfu_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
      send_request(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h8000_0001);

      // capacity lowered below occupancy
      write_capacity(5'd1);
      send_request(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
      send_request(lfu_pkg::OP_PUT, 32'h1357_9BDF, 32'h2468_ACE0);
      send_request(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);

      // random phases over several capacities, keys mostly from a small pool
      for (int p = 0; p < 9; p++) begin
         write_capacity(phase_caps[p]);
         quiet_sender = (p % 3 == 2);
         span = $urandom_range(2, KEY_POOL);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            op = $urandom_range(0, 1) ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET;
            key = ($urandom_range(0, 9) < 9) ? key_pool[$urandom_range(0, span - 1)]
                                             : $urandom();
            // hold off until the block has answered everything
            if ($urandom_range(0, 79) == 0)
               wait_drained();
            send_request(op, key, $urandom());
         end
      end

      req_chan.valid = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
